// File: rtl/asr_pkg.sv
// Shared types, constants and small lookup functions for the averaged scale readout.
// Used by every module of the block; depends on nothing else.

package asr_pkg;

   localparam int ADC_BITS    = 12;
   localparam int COUNT_W     = 8;
   localparam int WEIGHT_W    = 14;
   localparam int NUM_DIGITS  = 4;
   localparam int POS_W       = 2;
   localparam int SEG_W       = 8;
   localparam int BCD_W       = 4 * NUM_DIGITS;

   // A window holds at most 2^COUNT_W samples, so the sum and divisor follow from that.
   localparam int SUM_W       = ADC_BITS + COUNT_W;
   localparam int DIVISOR_W   = COUNT_W + 1;
   localparam int DIV_CNT_W   = $clog2(SUM_W);
   localparam int PROD_W      = ADC_BITS + WEIGHT_W;
   localparam int DD_W        = BCD_W + WEIGHT_W;
   localparam int DD_CNT_W    = $clog2(WEIGHT_W);

   localparam int REQ_W       = ((ADC_BITS + 1 + 7) / 8) * 8;
   localparam int RSP_USED_W  = WEIGHT_W + 3 + POS_W + SEG_W;
   localparam int RSP_W       = ((RSP_USED_W + 7) / 8) * 8;

   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = $clog2(QDEPTH);

   localparam int CSR_ADDR_W  = 1;
   localparam logic [CSR_ADDR_W-1:0] REG_SAMPLE_COUNT = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_FULL_SCALE   = 1'd1;

   localparam logic [COUNT_W-1:0]  SAMPLE_COUNT_RESET = 8'd5;
   localparam logic [WEIGHT_W-1:0] FULL_SCALE_RESET   = 14'd500;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX         = 14'd9999;
   localparam logic [SEG_W-1:0]    DP_BIT             = 8'h80;

   // Action codes on the request side.
   localparam logic [1:0] ACT_SAMPLE = 2'd0;
   localparam logic [1:0] ACT_KEY    = 2'd1;
   localparam logic [1:0] ACT_SCAN   = 2'd2;

   // Work kinds after classification.
   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_TOGGLE = 2'd1;
   localparam logic [1:0] KIND_SCAN   = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   typedef struct packed {
      logic [1:0]          kind;
      logic [ADC_BITS-1:0] sample;
   } item_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  sample_count;
      logic [WEIGHT_W-1:0] full_scale;
   } cfg_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic                average_done;
      logic                report;
      logic                kg_mode;
      logic [POS_W-1:0]    digit_position;
      logic [SEG_W-1:0]    segments;
   } rsp_type;

   function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
      logic [SEG_W-1:0] code;
      case (digit)
         4'd0:    code = 8'h3F;
         4'd1:    code = 8'h06;
         4'd2:    code = 8'h5B;
         4'd3:    code = 8'h4F;
         4'd4:    code = 8'h66;
         4'd5:    code = 8'h6D;
         4'd6:    code = 8'h7D;
         4'd7:    code = 8'h07;
         4'd8:    code = 8'h7F;
         4'd9:    code = 8'h6F;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

// File: rtl/asr_front.sv
// Front end: accepts request transactions, classifies them and holds them in a short queue.
// Depends on asr_pkg.

module asr_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [1:0]                   in_action,
   input  logic [asr_pkg::ADC_BITS-1:0] in_sample,
   input  logic                         in_key,
   output logic                         q_valid,
   output asr_pkg::item_type            q_item,
   input  logic                         q_pop
);

   asr_pkg::item_type             q_ff [asr_pkg::QDEPTH];
   logic [asr_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [asr_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [asr_pkg::QPTR_W:0]      count_ff, count_in;
   asr_pkg::item_type             item;
   logic                          push;
   logic                          pop;

   // A key event with the key released changes nothing, so it is queued as a no-op.
   always_comb begin
      item.sample = in_sample;
      case (in_action)
         asr_pkg::ACT_SAMPLE: item.kind = asr_pkg::KIND_SAMPLE;
         asr_pkg::ACT_KEY:    item.kind = in_key ? asr_pkg::KIND_TOGGLE : asr_pkg::KIND_NONE;
         asr_pkg::ACT_SCAN:   item.kind = asr_pkg::KIND_SCAN;
         default:             item.kind = asr_pkg::KIND_NONE;
      endcase
   end

   assign in_ready = (count_ff != (asr_pkg::QPTR_W+1)'(asr_pkg::QDEPTH));
   assign push     = in_valid && in_ready;
   assign q_valid  = (count_ff != '0);
   assign pop      = q_pop && q_valid;
   assign q_item   = q_ff[rd_ptr_ff];

   // The depth is a power of two, so the pointers wrap on their own.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// File: rtl/asr_div.sv
// Restoring serial divider, one quotient bit per cycle, for the sample average.
// Depends on asr_pkg.

module asr_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [asr_pkg::SUM_W-1:0]     dividend,
   input  logic [asr_pkg::DIVISOR_W-1:0] divisor,
   output logic                          done,
   output logic [asr_pkg::SUM_W-1:0]     quotient
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [asr_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [asr_pkg::DIVISOR_W-1:0]   dvs_ff, dvs_in;
   logic [asr_pkg::DIVISOR_W-1:0]   rem_ff, rem_in;
   logic [asr_pkg::SUM_W-1:0]       quo_ff, quo_in;
   logic [asr_pkg::DIVISOR_W:0]     rem_sh;
   logic [asr_pkg::DIVISOR_W:0]     rem_sub;
   logic                            ge;

   // The quotient register starts as the dividend and shifts quotient bits in from the bottom.
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[asr_pkg::SUM_W-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      ge      = (rem_sh >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvs_in  = divisor;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[asr_pkg::DIVISOR_W-1:0] : rem_sh[asr_pkg::DIVISOR_W-1:0];
         quo_in = {quo_ff[asr_pkg::SUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == asr_pkg::DIV_CNT_W'(asr_pkg::SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/asr_back.sv
// Back end: sample accumulation, weight scaling, decimal conversion, display scan
// and the result register. Depends on asr_pkg and asr_div.

module asr_back (
   input  logic              clock,
   input  logic              reset,
   input  asr_pkg::cfg_type  cfg,
   input  logic              q_valid,
   input  asr_pkg::item_type q_item,
   output logic              q_pop,
   output logic              out_valid,
   input  logic              out_ready,
   output asr_pkg::rsp_type  out_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_SAT  = 3'd3;
   localparam logic [2:0] S_BCD  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0]                       state_ff, state_in;
   logic [asr_pkg::SUM_W-1:0]        sum_ff, sum_in;
   logic [asr_pkg::COUNT_W-1:0]      taken_ff, taken_in;
   logic [asr_pkg::WEIGHT_W-1:0]     cur_w_ff, cur_w_in;
   logic [asr_pkg::WEIGHT_W-1:0]     rep_w_ff, rep_w_in;
   logic                             report_ff, report_in;
   logic                             mode_ff, mode_in;
   logic [asr_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [asr_pkg::NUM_DIGITS-1:0][3:0] bcd_ff, bcd_in;
   logic [asr_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic [asr_pkg::DD_W-1:0]         dd_ff, dd_in;
   logic [asr_pkg::DD_CNT_W-1:0]     dd_cnt_ff, dd_cnt_in;
   logic                             out_valid_ff, out_valid_in;
   asr_pkg::rsp_type                 out_ff, out_in;

   logic                             out_free;
   logic                             pop;
   logic [asr_pkg::SUM_W-1:0]        sum_new;
   logic [asr_pkg::COUNT_W-1:0]      taken_new;
   logic [asr_pkg::COUNT_W-1:0]      need;
   logic                             window_full;
   logic [asr_pkg::DIVISOR_W-1:0]    divisor;
   logic                             div_start;
   logic                             div_done;
   logic [asr_pkg::SUM_W-1:0]        quotient;
   logic [asr_pkg::WEIGHT_W-1:0]     w_raw;
   logic [asr_pkg::WEIGHT_W-1:0]     w_sat;
   logic [3:0]                       digit;
   logic [asr_pkg::SEG_W-1:0]        segs;

   // One double-dabble step: fix up every decimal digit, then shift the whole word left.
   function automatic logic [asr_pkg::DD_W-1:0] dd_step(input logic [asr_pkg::DD_W-1:0] v);
      logic [asr_pkg::DD_W-1:0] t;
      t = v;
      for (int i = 0; i < asr_pkg::NUM_DIGITS; i++) begin
         if (t[asr_pkg::WEIGHT_W + 4*i +: 4] >= 4'd5) begin
            t[asr_pkg::WEIGHT_W + 4*i +: 4] = t[asr_pkg::WEIGHT_W + 4*i +: 4] + 4'd3;
         end
      end
      return {t[asr_pkg::DD_W-2:0], 1'b0};
   endfunction

   asr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_new),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   assign out_free = !out_valid_ff || out_ready;
   assign pop      = (state_ff == S_IDLE) && q_valid && out_free;
   assign q_pop    = pop;

   always_comb begin
      sum_new     = sum_ff + {{asr_pkg::COUNT_W{1'b0}}, q_item.sample};
      taken_new   = taken_ff + 1'b1;
      need        = (cfg.sample_count == '0) ? asr_pkg::COUNT_W'(1) : cfg.sample_count;
      // A count that wraps to zero means a full window of 2^COUNT_W samples.
      window_full = (taken_new >= need) || (taken_new == '0);
      divisor     = (taken_new == '0) ? {1'b1, {asr_pkg::COUNT_W{1'b0}}} : {1'b0, taken_new};
      div_start   = pop && (q_item.kind == asr_pkg::KIND_SAMPLE) && window_full;
      w_raw       = prod_ff[asr_pkg::PROD_W-1:asr_pkg::ADC_BITS];
      w_sat       = (w_raw > asr_pkg::WEIGHT_MAX) ? asr_pkg::WEIGHT_MAX : w_raw;
      digit       = bcd_ff[pos_ff];
      segs        = asr_pkg::seg_code(digit);
      if ((pos_ff == asr_pkg::POS_W'(asr_pkg::NUM_DIGITS - 1)) && mode_ff && (digit == 4'd0)) begin
         segs = segs | asr_pkg::DP_BIT;
      end
   end

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      taken_in     = taken_ff;
      cur_w_in     = cur_w_ff;
      rep_w_in     = rep_w_ff;
      report_in    = report_ff;
      mode_in      = mode_ff;
      pos_in       = pos_ff;
      bcd_in       = bcd_ff;
      prod_in      = prod_ff;
      dd_in        = dd_ff;
      dd_cnt_in    = dd_cnt_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !out_ready;

      out_in.weight         = out_ff.weight;
      out_in.average_done   = out_ff.average_done;

      case (state_ff)
         S_IDLE: begin
            if (pop) begin
               out_in.weight         = cur_w_ff;
               out_in.average_done   = 1'b0;
               out_in.report         = 1'b0;
               out_in.kg_mode        = mode_ff;
               out_in.digit_position = pos_ff;
               out_in.segments       = '0;
               out_valid_in          = 1'b1;
               case (q_item.kind)
                  asr_pkg::KIND_SAMPLE: begin
                     if (window_full) begin
                        sum_in       = '0;
                        taken_in     = '0;
                        out_valid_in = out_valid_ff && !out_ready;
                        out_in       = out_ff;
                        state_in     = S_DIV;
                     end else begin
                        sum_in   = sum_new;
                        taken_in = taken_new;
                     end
                  end
                  asr_pkg::KIND_TOGGLE: begin
                     mode_in        = !mode_ff;
                     out_in.kg_mode = !mode_ff;
                  end
                  asr_pkg::KIND_SCAN: begin
                     out_in.segments = segs;
                     pos_in          = pos_ff + 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = quotient[asr_pkg::ADC_BITS-1:0] * cfg.full_scale;
            state_in = S_SAT;
         end
         S_SAT: begin
            cur_w_in  = w_sat;
            report_in = (w_sat != rep_w_ff);
            rep_w_in  = w_sat;
            dd_in     = {{asr_pkg::BCD_W{1'b0}}, w_sat};
            dd_cnt_in = '0;
            state_in  = S_BCD;
         end
         S_BCD: begin
            dd_in     = dd_step(dd_ff);
            dd_cnt_in = dd_cnt_ff + 1'b1;
            if (dd_cnt_ff == asr_pkg::DD_CNT_W'(asr_pkg::WEIGHT_W - 1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            bcd_in = dd_ff[asr_pkg::DD_W-1:asr_pkg::WEIGHT_W];
            if (out_free) begin
               out_in.weight         = cur_w_ff;
               out_in.average_done   = 1'b1;
               out_in.report         = report_ff;
               out_in.kg_mode        = mode_ff;
               out_in.digit_position = pos_ff;
               out_in.segments       = '0;
               out_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         taken_ff     <= '0;
         cur_w_ff     <= '0;
         rep_w_ff     <= '0;
         report_ff    <= 1'b0;
         mode_ff      <= 1'b0;
         pos_ff       <= '0;
         bcd_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         taken_ff     <= taken_in;
         cur_w_ff     <= cur_w_in;
         rep_w_ff     <= rep_w_in;
         report_ff    <= report_in;
         mode_ff      <= mode_in;
         pos_ff       <= pos_in;
         bcd_ff       <= bcd_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      dd_ff     <= dd_in;
      dd_cnt_ff <= dd_cnt_in;
      out_ff    <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

// File: rtl/averaged_scale_readout_top.sv
// Top level of the averaged scale readout: configuration registers, front end and back end.
// Depends on asr_pkg, asr_front and asr_back.
//
//   channel   direction   handshake              payload
//   req       in          req_tvalid/tready      tuser action, tdata sample and key level
//   rsp       out         rsp_tvalid/tready      tdata weight, flags, digit and segments
//   csr       in          csr_we                 csr_addr register index, csr_wdata value
//
// A key event, a scan tick or a sample that does not close a window is handled in the back
// end's idle state. A sample that closes a window goes through 20 steps of the serial
// divider, a multiply and saturate, and 14 steps of the binary-to-decimal conversion.
// Reset is synchronous and clears all control and weight state. The queue keeps taking
// transactions, until it is full, while the back end is busy or the result is stalled.

module averaged_scale_readout_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [asr_pkg::REQ_W-1:0]        req_tdata,   // sample_value, key_level
   input  logic [1:0]                       req_tuser,   // action
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [asr_pkg::RSP_W-1:0]        rsp_tdata,   // weight, average_done, report,
                                                         // kg_mode, digit_position, segments
   input  logic                             csr_we,
   input  logic [asr_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [asr_pkg::WEIGHT_W-1:0]     csr_wdata
);

   asr_pkg::cfg_type   cfg_ff, cfg_in;
   logic               q_valid;
   logic               q_pop;
   asr_pkg::item_type  q_item;
   asr_pkg::rsp_type   rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            asr_pkg::REG_SAMPLE_COUNT: cfg_in.sample_count = csr_wdata[asr_pkg::COUNT_W-1:0];
            asr_pkg::REG_FULL_SCALE:   cfg_in.full_scale   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_count <= asr_pkg::SAMPLE_COUNT_RESET;
         cfg_ff.full_scale   <= asr_pkg::FULL_SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   asr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_action (req_tuser),
      .in_sample (req_tdata[asr_pkg::ADC_BITS-1:0]),
      .in_key    (req_tdata[asr_pkg::ADC_BITS]),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   asr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   assign rsp_tdata = {{(asr_pkg::RSP_W - asr_pkg::RSP_USED_W){1'b0}},
                       rsp.segments, rsp.digit_position, rsp.kg_mode,
                       rsp.report, rsp.average_done, rsp.weight};

endmodule
